@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the pion reconstruction RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PI0_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PI0_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define PI0_ASSERT(lbl, clk, rst, prop, msg)
`define PI0_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/pi0ftp_pkg.sv @@
// Shared constants and width helpers for the pion reconstruction pipeline.
package pi0ftp_pkg;
  localparam int LEN_W = 32;
  localparam int MASS_W = 16;
  localparam logic [MASS_W-1:0] MASS_RESET = 16'd2160;

  function automatic int lane_lat(input int eb);
    return eb + LEN_W + 4;
  endfunction

  function automatic int merge_rad_w(input int eb);
    return (2 * eb + 6 > 2 * MASS_W + 2) ? 2 * eb + 6 : 2 * MASS_W + 2;
  endfunction

  function automatic int merge_lat(input int eb);
    return merge_rad_w(eb) / 2 + 4;
  endfunction
endpackage

@@ rtl/core/pi0ftp_isqrt.sv @@
// Pipelined integer square root, one root bit per stage, with a sideband.
module pi0ftp_isqrt #(
  parameter int IN_W = 64,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                en,
  input  logic [IN_W-1:0]     rad,
  input  logic [SIDE_W-1:0]   side_in,
  output logic [IN_W/2-1:0]   root,
  output logic [SIDE_W-1:0]   side_out
);
  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 2;

  logic [REM_W-1:0]  rem_q  [OUT_W];
  logic [OUT_W-1:0]  root_q [OUT_W];
  logic [IN_W-1:0]   rad_q  [OUT_W];
  logic [SIDE_W-1:0] side_q [OUT_W];

  for (genvar s = 0; s < OUT_W; s++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [OUT_W-1:0]  root_in;
    logic [IN_W-1:0]   rad_in;
    logic [SIDE_W-1:0] side_i;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
      assign side_i  = side_in;
    end else begin : g_rest
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign side_i  = side_q[s-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], rad_in[IN_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= ge ? rem_sh - trial : rem_sh;
        root_q[s] <= {root_in[OUT_W-2:0], ge};
        rad_q[s]  <= {rad_in[IN_W-3:0], 2'b00};
        side_q[s] <= side_i;
      end
    end
  end

  assign root     = root_q[OUT_W-1];
  assign side_out = side_q[OUT_W-1];
endmodule

@@ rtl/core/pi0ftp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage; quotient must fit Q_W.
module pi0ftp_div #(
  parameter int NUM_W = 56,
  parameter int Q_W = 24,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [NUM_W-1:0]       num,
  input  logic [NUM_W-Q_W-1:0]   den,
  input  logic [SIDE_W-1:0]      side_in,
  output logic [Q_W-1:0]         quo,
  output logic [SIDE_W-1:0]      side_out
);
  localparam int DEN_W = NUM_W - Q_W;

  logic [DEN_W-1:0]  rem_q  [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [Q_W-1:0]    low_q  [Q_W];
  logic [Q_W-1:0]    quo_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic [DEN_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [Q_W-1:0]    low_in;
    logic [Q_W-1:0]    quo_in;
    logic [SIDE_W-1:0] side_i;
    logic [DEN_W:0]    rsh;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in = num[NUM_W-1:Q_W];
      assign den_in = den;
      assign low_in = num[Q_W-1:0];
      assign quo_in = '0;
      assign side_i = side_in;
    end else begin : g_rest
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
      assign side_i = side_q[s-1];
    end

    assign rsh  = {rem_in, low_in[Q_W-1]};
    assign ge   = rsh >= {1'b0, den_in};
    assign diff = rsh - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= ge ? diff[DEN_W-1:0] : rsh[DEN_W-1:0];
        den_q[s]  <= den_in;
        low_q[s]  <= low_in << 1;
        quo_q[s]  <= {quo_in[Q_W-2:0], ge};
        side_q[s] <= side_i;
      end
    end
  end

  assign quo      = quo_q[Q_W-1];
  assign side_out = side_q[Q_W-1];
endmodule

@@ rtl/core/pi0ftp_photon.sv @@
// Photon lane: normalize one direction and scale it by the photon energy.
module pi0ftp_photon #(
  parameter int EB = 24,
  parameter int DB = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [DB-1:0] dir_x,
  input  logic signed [DB-1:0] dir_y,
  input  logic signed [DB-1:0] dir_z,
  input  logic [EB-1:0]       energy,
  output logic signed [EB:0]  p_x,
  output logic signed [EB:0]  p_y,
  output logic signed [EB:0]  p_z
);
  import pi0ftp_pkg::*;

  localparam int F = LEN_W - DB;
  localparam int N_W = EB + DB;
  localparam int NUM_W = N_W + F;
  localparam int SIDE_W = 3 * N_W + 4;

  logic [DB-1:0]   mag [3];
  logic [DB-1:0]   mag1 [3];
  logic [2:0]      neg1;
  logic [EB-1:0]   e1;
  logic [2*DB-1:0] sq2 [3];
  logic [N_W-1:0]  n2 [3];
  logic [2:0]      neg2;
  logic [2*DB-1:0] s3;
  logic [N_W-1:0]  n3 [3];
  logic [2:0]      neg3;
  logic            zero3;
  logic [LEN_W-1:0] len;
  logic [SIDE_W-1:0] sq_side;
  logic [EB-1:0]   quo [3];
  logic [1:0]      dside [3];
  logic signed [EB:0] p_q [3];
  logic signed [DB-1:0] dir [3];

  assign dir[0] = dir_x;
  assign dir[1] = dir_y;
  assign dir[2] = dir_z;

  for (genvar i = 0; i < 3; i++) begin : g_mag
    assign mag[i] = dir[i][DB-1] ? DB'(~dir[i]) + DB'(1) : DB'(dir[i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= mag[i];
        neg1[i] <= dir[i][DB-1];
        sq2[i]  <= mag1[i] * mag1[i];
        n2[i]   <= mag1[i] * e1;
        n3[i]   <= n2[i];
      end
      e1    <= energy;
      neg2  <= neg1;
      neg3  <= neg2;
      s3    <= sq2[0] + sq2[1] + sq2[2];
      zero3 <= (sq2[0] | sq2[1] | sq2[2]) == '0;
    end
  end

  pi0ftp_isqrt #(.IN_W(2 * LEN_W), .SIDE_W(SIDE_W)) u_len (
    .clk(clk), .en(en),
    .rad({s3, {(2 * F){1'b0}}}),
    .side_in({n3[0], n3[1], n3[2], neg3, zero3}),
    .root(len), .side_out(sq_side)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    pi0ftp_div #(.NUM_W(NUM_W), .Q_W(EB), .SIDE_W(2)) u_div (
      .clk(clk), .en(en),
      .num({sq_side[SIDE_W-1-i*N_W -: N_W], {F{1'b0}}}),
      .den(len),
      .side_in({sq_side[1+i], sq_side[0]}),
      .quo(quo[i]), .side_out(dside[i])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        if (dside[i][0])
          p_q[i] <= '0;
        else if (dside[i][1])
          p_q[i] <= -$signed({1'b0, quo[i]});
        else
          p_q[i] <= $signed({1'b0, quo[i]});
      end
    end
  end

  assign p_x = p_q[0];
  assign p_y = p_q[1];
  assign p_z = p_q[2];
endmodule

@@ rtl/core/pi0ftp_merge.sv @@
// Merge stage: sum photon momenta, then pion magnitude, energy and kinetic energy.
module pi0ftp_merge #(
  parameter int EB = 24
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [pi0ftp_pkg::MASS_W-1:0]     mass,
  input  logic [3*(EB+1)-1:0]               g1,
  input  logic [3*(EB+1)-1:0]               g2,
  output logic [3*(EB+2)-1:0]               pion_p,
  output logic [EB+1:0]                     pion_momentum,
  output logic [EB+1:0]                     pion_energy,
  output logic [EB+1:0]                     pion_kinetic,
  output logic [3*(EB+1)-1:0]               g1_out,
  output logic [3*(EB+1)-1:0]               g2_out
);
  import pi0ftp_pkg::*;

  localparam int PW = EB + 2;
  localparam int GW = EB + 1;
  localparam int RAD_W = merge_rad_w(EB);
  localparam int R_W = RAD_W / 2;
  localparam int SIDE_W = 3 * PW + 6 * GW;
  localparam int K_W = PW + MASS_W + 1;

  logic signed [PW-1:0] pi_a [3];
  logic [3*GW-1:0] g1_a, g2_a, g1_b, g2_b, g1_c, g2_c;
  logic [3*PW-1:0] pi_b, pi_c;
  logic [2*PW-1:0] sq_b [3];
  logic [2*MASS_W-1:0] m2_b;
  logic [MASS_W-1:0] mass_b, mass_c;
  logic [RAD_W-1:0] p2_c, e2_c;
  logic [R_W-1:0] p_root, e_root;
  logic [SIDE_W-1:0] p_side;
  logic [MASS_W-1:0] e_side;
  logic [PW-1:0] pmag_sat, e_sat;
  logic [K_W-1:0] kin_diff;
  logic [SIDE_W-1:0] side_d;
  logic [PW-1:0] pmag_d, e_d, kin_d;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pi_a[i] <= $signed({g1[i*GW+GW-1], g1[i*GW +: GW]})
                 + $signed({g2[i*GW+GW-1], g2[i*GW +: GW]});
        pi_b[i*PW +: PW] <= pi_a[i];
        sq_b[i] <= (pi_a[i][PW-1] ? PW'(-pi_a[i]) : PW'(pi_a[i]))
                 * (pi_a[i][PW-1] ? PW'(-pi_a[i]) : PW'(pi_a[i]));
      end
      g1_a   <= g1;
      g2_a   <= g2;
      g1_b   <= g1_a;
      g2_b   <= g2_a;
      m2_b   <= mass * mass;
      mass_b <= mass;
      pi_c   <= pi_b;
      g1_c   <= g1_b;
      g2_c   <= g2_b;
      mass_c <= mass_b;
      p2_c   <= RAD_W'(sq_b[0]) + RAD_W'(sq_b[1]) + RAD_W'(sq_b[2]);
      e2_c   <= RAD_W'(sq_b[0]) + RAD_W'(sq_b[1]) + RAD_W'(sq_b[2]) + RAD_W'(m2_b);
    end
  end

  pi0ftp_isqrt #(.IN_W(RAD_W), .SIDE_W(SIDE_W)) u_psqrt (
    .clk(clk), .en(en), .rad(p2_c), .side_in({pi_c, g1_c, g2_c}),
    .root(p_root), .side_out(p_side)
  );

  pi0ftp_isqrt #(.IN_W(RAD_W), .SIDE_W(MASS_W)) u_esqrt (
    .clk(clk), .en(en), .rad(e2_c), .side_in(mass_c),
    .root(e_root), .side_out(e_side)
  );

  // saturate roots at the all-ones value of the output width
  assign pmag_sat = (|p_root[R_W-1:PW]) ? '1 : p_root[PW-1:0];
  assign e_sat    = (|e_root[R_W-1:PW]) ? '1 : e_root[PW-1:0];
  assign kin_diff = K_W'(e_sat) - K_W'(e_side);

  always_ff @(posedge clk) begin
    if (en) begin
      side_d <= p_side;
      pmag_d <= pmag_sat;
      e_d    <= e_sat;
      kin_d  <= kin_diff[K_W-1] ? '0 : kin_diff[PW-1:0];
    end
  end

  assign pion_p        = side_d[SIDE_W-1 -: 3*PW];
  assign g1_out        = side_d[6*GW-1 -: 3*GW];
  assign g2_out        = side_d[3*GW-1:0];
  assign pion_momentum = pmag_d;
  assign pion_energy   = e_d;
  assign pion_kinetic  = kin_d;
endmodule

@@ rtl/core/pi0_from_two_photons.sv @@
// Top level: two photon lanes, merge stage and output skid buffer.
//   channel  dir  beat contents
//   s_axis   in   two photon directions and energies
//   m_axis   out  pion momentum, magnitude, energy, kinetic, both photon momenta
//   cfg      in   pion_mass write (no read-back)
// One pair per cycle while the skid is empty; a full skid stalls the input.
// The per-bit square root and divider stages of lanes and merge set the depth.
// rst clears the valid chain, skid and output valid, and loads the mass reset value.
// A stalled output takes one more result into the skid before the pipeline freezes.
`include "assert_macros.svh"
module pi0_from_two_photons #(
  parameter int ENERGY_BITS = 24,
  parameter int DIR_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [pi0ftp_pkg::MASS_W-1:0] cfg_wdata,
  input  logic s_tvalid,
  output logic s_tready,
  // first_dir_x, first_dir_y, first_dir_z, second_dir_x, second_dir_y, second_dir_z,
  // first_energy, second_energy
  input  logic [((6*DIR_BITS+2*ENERGY_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // pion_px, pion_py, pion_pz, pion_momentum, pion_energy, pion_kinetic,
  // first_px, first_py, first_pz, second_px, second_py, second_pz
  output logic [((12*ENERGY_BITS+18+7)/8)*8-1:0] m_tdata
);
  import pi0ftp_pkg::*;

  localparam int EB = ENERGY_BITS;
  localparam int DB = DIR_BITS;
  localparam int PW = EB + 2;
  localparam int GW = EB + 1;
  localparam int OUT_W = ((12*EB+18+7)/8)*8;
  localparam int LAT = lane_lat(EB) + merge_lat(EB);
  localparam int MOM_LO = 3 * PW;
  localparam int EN_LO = 4 * PW;
  localparam int KIN_LO = 5 * PW;

  logic [MASS_W-1:0] mass;
  logic en;
  logic [LAT-1:0] vld;
  logic skid_valid;
  logic [OUT_W-1:0] skid_data, pipe_data;
  logic [3*GW-1:0] g1, g2, g1_out, g2_out;
  logic [3*PW-1:0] pion_p;
  logic [PW-1:0] pmom, pen, pkin;
  logic signed [GW-1:0] g1x, g1y, g1z, g2x, g2y, g2z;

  always_ff @(posedge clk) begin
    if (rst) begin
      mass <= MASS_RESET;
    end else if (cfg_we) begin
      mass <= cfg_wdata;
    end
  end

  assign en = !skid_valid;
  assign s_tready = en;

  pi0ftp_photon #(.EB(EB), .DB(DB)) u_first (
    .clk(clk), .en(en),
    .dir_x(s_tdata[0*DB +: DB]), .dir_y(s_tdata[1*DB +: DB]), .dir_z(s_tdata[2*DB +: DB]),
    .energy(s_tdata[6*DB +: EB]),
    .p_x(g1x), .p_y(g1y), .p_z(g1z)
  );

  pi0ftp_photon #(.EB(EB), .DB(DB)) u_second (
    .clk(clk), .en(en),
    .dir_x(s_tdata[3*DB +: DB]), .dir_y(s_tdata[4*DB +: DB]), .dir_z(s_tdata[5*DB +: DB]),
    .energy(s_tdata[6*DB+EB +: EB]),
    .p_x(g2x), .p_y(g2y), .p_z(g2z)
  );

  assign g1 = {g1z, g1y, g1x};
  assign g2 = {g2z, g2y, g2x};

  pi0ftp_merge #(.EB(EB)) u_merge (
    .clk(clk), .en(en), .mass(mass), .g1(g1), .g2(g2),
    .pion_p(pion_p), .pion_momentum(pmom), .pion_energy(pen), .pion_kinetic(pkin),
    .g1_out(g1_out), .g2_out(g2_out)
  );

  assign pipe_data = OUT_W'({g2_out, g1_out, pkin, pen, pmom, pion_p});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tvalid && !m_tready) begin
      // hold the output beat, park a finishing result in the skid
      if (en && vld[LAT-1]) begin
        skid_valid <= 1'b1;
        skid_data  <= pipe_data;
      end
    end else if (skid_valid) begin
      m_tvalid   <= 1'b1;
      m_tdata    <= skid_data;
      skid_valid <= 1'b0;
    end else begin
      m_tvalid <= vld[LAT-1];
      m_tdata  <= pipe_data;
    end
  end

  `PI0_ASSERT_IMP(a_skid_needs_out, clk, rst, skid_valid, m_tvalid, "skid full without output beat")
  `PI0_ASSERT_IMP(a_mom_le_energy, clk, rst, m_tvalid, m_tdata[MOM_LO +: PW] <= m_tdata[EN_LO +: PW], "momentum above energy")
  `PI0_ASSERT_IMP(a_kin_le_energy, clk, rst, m_tvalid, m_tdata[KIN_LO +: PW] <= m_tdata[EN_LO +: PW], "kinetic above energy")
endmodule
